@@ rtl/wsr_pkg.sv @@
package wsr_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned FinLimit   = 5;
  localparam int unsigned RtoFloor   = 10;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_ACK   = 2'd1,
    FUNC_START = 2'd2,
    FUNC_OTHER = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_SYN  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_FIN  = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_SEGMENT_SIZE    = 3'd0,
    REG_WINDOW_SEGMENTS = 3'd1,
    REG_INITIAL_TIMEOUT = 3'd2,
    REG_TOTAL_LENGTH    = 3'd3,
    REG_INITIAL_SEQ     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SYN  = 3'd1,
    PH_DATA = 3'd2,
    PH_FIN  = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_DISPATCH,
    C_ADVANCE,
    C_FILL,
    C_RD,
    C_EV,
    C_RTT1,
    C_RTT2,
    C_RTT3,
    C_FLUSH
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_START,
    OP_SYN_RESEND,
    OP_SYN_ACKED,
    OP_FILL,
    OP_FIN_FIRST,
    OP_FIN_RETRY,
    OP_FINISH,
    OP_SCAN_INIT,
    OP_SCAN_EV,
    OP_RTT1,
    OP_RTT2,
    OP_RTT3,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       syn_ack_match;
    logic       fin_ack_match;
    logic       timed;
    logic       fin_limit;
    logic       outstanding_zero;
    logic       bytes_left_zero;
    logic       fill_more;
    logic       scan_end;
    logic       rtt_upd;
    logic       emit_ok;
    logic       pend_valid;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/wsr_ctrl.sv @@
module wsr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  wsr_pkg::sts_t sts,
  output wsr_pkg::cmd_t cmd,
  output logic          busy
);

  wsr_pkg::ctl_state_t state, state_next;
  wsr_pkg::phase_t     phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsr_pkg::C_IDLE;
      phase <= wsr_pkg::PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op     = wsr_pkg::OP_NONE;
    case (state)
      wsr_pkg::C_IDLE: begin
        if (in_valid) begin
          cmd.op     = wsr_pkg::OP_LATCH;
          state_next = wsr_pkg::C_DISPATCH;
        end
      end
      wsr_pkg::C_DISPATCH: begin
        state_next = wsr_pkg::C_FLUSH;
        if (sts.func == wsr_pkg::FUNC_START) begin
          cmd.op     = wsr_pkg::OP_START;
          phase_next = wsr_pkg::PH_SYN;
        end else begin
          case (phase)
            wsr_pkg::PH_SYN: begin
              if (sts.func == wsr_pkg::FUNC_ACK && sts.syn_ack_match) begin
                cmd.op     = wsr_pkg::OP_SYN_ACKED;
                phase_next = wsr_pkg::PH_DATA;
                state_next = wsr_pkg::C_ADVANCE;
              end else if (sts.func == wsr_pkg::FUNC_ACK || sts.timed) begin
                cmd.op = wsr_pkg::OP_SYN_RESEND;
              end
            end
            wsr_pkg::PH_DATA: begin
              cmd.op     = wsr_pkg::OP_SCAN_INIT;
              state_next = wsr_pkg::C_RD;
            end
            wsr_pkg::PH_FIN: begin
              if (sts.func == wsr_pkg::FUNC_ACK && sts.fin_ack_match) begin
                cmd.op     = wsr_pkg::OP_FINISH;
                phase_next = wsr_pkg::PH_DONE;
              end else if (sts.func == wsr_pkg::FUNC_ACK || sts.timed) begin
                if (sts.fin_limit) begin
                  cmd.op     = wsr_pkg::OP_FINISH;
                  phase_next = wsr_pkg::PH_DONE;
                end else begin
                  cmd.op = wsr_pkg::OP_FIN_RETRY;
                end
              end
            end
            default: ;
          endcase
        end
      end
      wsr_pkg::C_ADVANCE: begin
        if (!sts.outstanding_zero) begin
          state_next = wsr_pkg::C_FLUSH;
        end else if (!sts.bytes_left_zero) begin
          state_next = wsr_pkg::C_FILL;
        end else if (sts.emit_ok) begin
          cmd.op     = wsr_pkg::OP_FIN_FIRST;
          phase_next = wsr_pkg::PH_FIN;
          state_next = wsr_pkg::C_FLUSH;
        end
      end
      wsr_pkg::C_FILL: begin
        if (!sts.fill_more) begin
          state_next = wsr_pkg::C_FLUSH;
        end else if (sts.emit_ok) begin
          cmd.op = wsr_pkg::OP_FILL;
        end
      end
      wsr_pkg::C_RD: begin
        state_next = sts.scan_end ? wsr_pkg::C_ADVANCE : wsr_pkg::C_EV;
      end
      wsr_pkg::C_EV: begin
        if (sts.emit_ok) begin
          cmd.op     = wsr_pkg::OP_SCAN_EV;
          state_next = sts.rtt_upd ? wsr_pkg::C_RTT1 : wsr_pkg::C_RD;
        end
      end
      wsr_pkg::C_RTT1: begin
        cmd.op     = wsr_pkg::OP_RTT1;
        state_next = wsr_pkg::C_RTT2;
      end
      wsr_pkg::C_RTT2: begin
        cmd.op     = wsr_pkg::OP_RTT2;
        state_next = wsr_pkg::C_RTT3;
      end
      wsr_pkg::C_RTT3: begin
        cmd.op     = wsr_pkg::OP_RTT3;
        state_next = wsr_pkg::C_RD;
      end
      wsr_pkg::C_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = wsr_pkg::C_IDLE;
        end else if (sts.out_free) begin
          cmd.op     = wsr_pkg::OP_FLUSH;
          state_next = wsr_pkg::C_IDLE;
        end
      end
      default: state_next = wsr_pkg::C_IDLE;
    endcase
  end

  assign busy = (state != wsr_pkg::C_IDLE);

endmodule

@@ rtl/wsr_datapath.sv @@
module wsr_datapath #(
  parameter int WINDOW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  wsr_pkg::cmd_t cmd,
  output wsr_pkg::sts_t sts,
  input  logic [1:0]    func,
  input  logic [31:0]   ack_num,
  input  logic [31:0]   now_ms,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    kind,
  output logic [31:0]   seq_num,
  output logic [31:0]   byte_offset,
  output logic [15:0]   seg_length,
  output logic          is_retransmit,
  output logic          last
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int OW = $clog2(WINDOW + 1);

  // Configuration registers.
  logic [15:0] segment_size;
  logic [4:0]  window_segments;
  logic [15:0] initial_timeout;
  logic [31:0] total_length;
  logic [14:0] initial_seq;

  // Transfer state.
  logic [31:0] seq_base, bytes_sent, bytes_left;
  logic [OW-1:0] outstanding;
  logic [31:0] smoothed_rtt, rtt_deviation, current_rto, control_sent_time;
  logic [2:0]  fin_tries;
  logic [WINDOW-1:0] slot_valid, slot_resent;

  // Latched item.
  logic [1:0]  func_q;
  logic [31:0] ack_q, now_q;
  logic        have_ack;

  logic [OW-1:0] idx;
  logic [31:0]   rtt;
  logic [4:0]    res_cnt;

  // Slot memories, read at the scan index.
  logic [31:0] mem_seq  [WINDOW];
  logic [15:0] mem_len  [WINDOW];
  logic [31:0] mem_time [WINDOW];
  logic [31:0] rd_seq, rd_time;
  logic [15:0] rd_len;

  // Pending result, held back until it is known whether it is the last one.
  logic        pend_valid, pend_retx;
  logic [1:0]  pend_kind;
  logic [31:0] pend_seq, pend_off;
  logic [15:0] pend_len;

  logic [IW-1:0] ridx, fidx;
  logic [OW-1:0] lim;
  logic [15:0]   seg, fill_len;
  logic          cur_valid, cur_resent, cur_match, cur_timeout;
  logic          out_free;

  logic          em;
  logic [1:0]    em_kind;
  logic [31:0]   em_seq, em_off;
  logic [15:0]   em_len;
  logic          em_retx;

  logic          mem_we_all, mem_we_time;
  logic [IW-1:0] mem_wa;
  logic [31:0]   mem_wseq, mem_wtime;

  logic signed [32:0] diff, quot, d2s;
  logic [31:0]   d2;
  logic [34:0]   dev_sum, rto_sum;

  assign ridx = idx[IW-1:0];
  assign fidx = outstanding[IW-1:0];
  assign seg  = (segment_size == 16'd0) ? 16'd1 : segment_size;
  assign fill_len = (bytes_left < {16'd0, seg}) ? bytes_left[15:0] : seg;

  always_comb begin
    if (window_segments == 5'd0) begin
      lim = OW'(1);
    end else if (32'(window_segments) > 32'(WINDOW)) begin
      lim = OW'(WINDOW);
    end else begin
      lim = OW'(window_segments);
    end
  end

  assign cur_valid   = slot_valid[ridx];
  assign cur_resent  = slot_resent[ridx];
  assign cur_match   = have_ack && ((rd_seq + {16'd0, rd_len}) == ack_q);
  assign cur_timeout = (now_q - rd_time) >= current_rto;
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    sts.func             = func_q;
    sts.syn_ack_match    = (ack_q == seq_base + 32'd1);
    sts.fin_ack_match    = (ack_q == seq_base + bytes_sent + 32'd1);
    sts.timed            = (now_q - control_sent_time) >= current_rto;
    sts.fin_limit        = (32'(fin_tries) >= wsr_pkg::FinLimit);
    sts.outstanding_zero = (outstanding == '0);
    sts.bytes_left_zero  = (bytes_left == 32'd0);
    sts.fill_more        = (outstanding < lim) && (bytes_left != 32'd0);
    sts.scan_end         = (idx == OW'(WINDOW));
    sts.rtt_upd          = cur_valid && cur_match && !cur_resent;
    sts.emit_ok          = !pend_valid || out_free;
    sts.pend_valid       = pend_valid;
    sts.out_free         = out_free;
  end

  // Result produced by the current operation.
  always_comb begin
    em      = 1'b0;
    em_kind = wsr_pkg::KIND_SYN;
    em_seq  = seq_base + bytes_sent;
    em_off  = 32'd0;
    em_len  = 16'd0;
    em_retx = 1'b0;
    case (cmd.op)
      wsr_pkg::OP_START: begin
        em     = 1'b1;
        em_seq = {17'd0, initial_seq};
      end
      wsr_pkg::OP_SYN_RESEND: begin
        em      = 1'b1;
        em_seq  = seq_base;
        em_retx = 1'b1;
      end
      wsr_pkg::OP_FILL: begin
        em      = 1'b1;
        em_kind = wsr_pkg::KIND_DATA;
        em_off  = bytes_sent;
        em_len  = fill_len;
      end
      wsr_pkg::OP_FIN_FIRST: begin
        em      = 1'b1;
        em_kind = wsr_pkg::KIND_FIN;
      end
      wsr_pkg::OP_FIN_RETRY: begin
        em      = 1'b1;
        em_kind = wsr_pkg::KIND_FIN;
        em_retx = 1'b1;
      end
      wsr_pkg::OP_FINISH: begin
        em      = 1'b1;
        em_kind = wsr_pkg::KIND_DONE;
        em_seq  = 32'd0;
      end
      wsr_pkg::OP_SCAN_EV: begin
        em      = cur_valid && !cur_match && cur_timeout;
        em_kind = wsr_pkg::KIND_DATA;
        em_seq  = rd_seq;
        em_off  = rd_seq - seq_base;
        em_len  = rd_len;
        em_retx = 1'b1;
      end
      default: ;
    endcase
  end

  // Slot memory write port.
  always_comb begin
    mem_we_all  = (cmd.op == wsr_pkg::OP_FILL);
    mem_we_time = (cmd.op == wsr_pkg::OP_SCAN_EV) && cur_valid && !cur_match && cur_timeout;
    mem_wa      = mem_we_all ? fidx : ridx;
    mem_wseq    = seq_base + bytes_sent;
    mem_wtime   = now_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we_all) begin
      mem_seq[mem_wa] <= mem_wseq;
      mem_len[mem_wa] <= fill_len;
    end
    if (mem_we_all || mem_we_time) begin
      mem_time[mem_wa] <= mem_wtime;
    end
    rd_seq  <= mem_seq[ridx];
    rd_len  <= mem_len[ridx];
    rd_time <= mem_time[ridx];
  end

  // Estimator arithmetic, one piece per step.
  always_comb begin
    diff = $signed({1'b0, rtt}) - $signed({1'b0, smoothed_rtt});
    quot = diff >>> 3;
    if (diff[32] && (diff[2:0] != 3'd0)) begin
      quot = quot + 33'sd1;
    end
    d2s = $signed({1'b0, rtt}) - $signed({1'b0, smoothed_rtt});
    d2  = d2s[32] ? 32'(-d2s) : d2s[31:0];
    dev_sum = 35'({rtt_deviation, 1'b0}) + 35'(rtt_deviation) + 35'(d2);
    rto_sum = 35'(smoothed_rtt) + 35'({rtt_deviation, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_size      <= 16'd1024;
      window_segments   <= 5'd16;
      initial_timeout   <= 16'd1000;
      total_length      <= 32'd0;
      initial_seq       <= 15'd0;
      seq_base          <= 32'd0;
      bytes_sent        <= 32'd0;
      bytes_left        <= 32'd0;
      outstanding       <= '0;
      smoothed_rtt      <= 32'd0;
      rtt_deviation     <= 32'd0;
      current_rto       <= 32'd0;
      control_sent_time <= 32'd0;
      fin_tries         <= 3'd0;
      slot_valid        <= '0;
      slot_resent       <= '0;
      func_q            <= wsr_pkg::FUNC_TICK;
      have_ack          <= 1'b0;
      idx               <= '0;
      res_cnt           <= 5'd0;
      pend_valid        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          wsr_pkg::REG_SEGMENT_SIZE:    segment_size    <= cfg_data[15:0];
          wsr_pkg::REG_WINDOW_SEGMENTS: window_segments <= cfg_data[4:0];
          wsr_pkg::REG_INITIAL_TIMEOUT: initial_timeout <= cfg_data[15:0];
          wsr_pkg::REG_TOTAL_LENGTH:    total_length    <= cfg_data;
          wsr_pkg::REG_INITIAL_SEQ:     initial_seq     <= cfg_data[14:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (cmd.op)
        wsr_pkg::OP_LATCH: begin
          func_q   <= func;
          ack_q    <= ack_num;
          now_q    <= now_ms;
          have_ack <= (func == wsr_pkg::FUNC_ACK);
          res_cnt  <= 5'd0;
        end
        wsr_pkg::OP_START: begin
          slot_valid        <= '0;
          slot_resent       <= '0;
          outstanding       <= '0;
          seq_base          <= {17'd0, initial_seq};
          bytes_sent        <= 32'd0;
          bytes_left        <= total_length;
          smoothed_rtt      <= {16'd0, initial_timeout};
          current_rto       <= {16'd0, initial_timeout};
          rtt_deviation     <= 32'd0;
          fin_tries         <= 3'd0;
          control_sent_time <= now_q;
        end
        wsr_pkg::OP_SYN_RESEND: control_sent_time <= now_q;
        wsr_pkg::OP_SYN_ACKED:  seq_base <= seq_base + 32'd1;
        wsr_pkg::OP_FILL: begin
          slot_valid[fidx]  <= 1'b1;
          slot_resent[fidx] <= 1'b0;
          bytes_sent        <= bytes_sent + {16'd0, fill_len};
          bytes_left        <= bytes_left - {16'd0, fill_len};
          outstanding       <= outstanding + OW'(1);
        end
        wsr_pkg::OP_FIN_FIRST: begin
          fin_tries         <= 3'd1;
          control_sent_time <= now_q;
        end
        wsr_pkg::OP_FIN_RETRY: begin
          fin_tries         <= fin_tries + 3'd1;
          control_sent_time <= now_q;
        end
        wsr_pkg::OP_SCAN_INIT: idx <= '0;
        wsr_pkg::OP_SCAN_EV: begin
          idx <= idx + OW'(1);
          if (cur_valid) begin
            if (cur_match) begin
              rtt               <= now_q - rd_time;
              slot_valid[ridx]  <= 1'b0;
              slot_resent[ridx] <= 1'b0;
              have_ack          <= 1'b0;
              if (outstanding != '0) begin
                outstanding <= outstanding - OW'(1);
              end
            end else if (cur_timeout) begin
              slot_resent[ridx] <= 1'b1;
            end
          end
        end
        wsr_pkg::OP_RTT1: smoothed_rtt  <= smoothed_rtt + quot[31:0];
        wsr_pkg::OP_RTT2: rtt_deviation <= dev_sum[33:2];
        wsr_pkg::OP_RTT3: begin
          if (rto_sum < 35'(wsr_pkg::RtoFloor)) begin
            current_rto <= 32'(wsr_pkg::RtoFloor);
          end else if (rto_sum > 35'h0_FFFF_FFFF) begin
            current_rto <= 32'hFFFF_FFFF;
          end else begin
            current_rto <= rto_sum[31:0];
          end
        end
        wsr_pkg::OP_FLUSH: begin
          pend_valid    <= 1'b0;
          out_valid     <= 1'b1;
          kind          <= pend_kind;
          seq_num       <= pend_seq;
          byte_offset   <= pend_off;
          seg_length    <= pend_len;
          is_retransmit <= pend_retx;
          last          <= 1'b1;
        end
        default: ;
      endcase

      if (em && (32'(res_cnt) < wsr_pkg::MaxResults)) begin
        res_cnt    <= res_cnt + 5'd1;
        pend_valid <= 1'b1;
        pend_kind  <= em_kind;
        pend_seq   <= em_seq;
        pend_off   <= em_off;
        pend_len   <= em_len;
        pend_retx  <= em_retx;
        if (pend_valid) begin
          out_valid     <= 1'b1;
          kind          <= pend_kind;
          seq_num       <= pend_seq;
          byte_offset   <= pend_off;
          seg_length    <= pend_len;
          is_retransmit <= pend_retx;
          last          <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/window_sender_retx_rto.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  func, ack_num, now_ms
// out       output     out_valid/out_stall  kind, seq_num, byte_offset, seg_length,
//                                           is_retransmit, last
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item at a time: the block takes and decodes it, then the scan visits the WINDOW slots,
// read from the slot memory, with an RTT estimate update in the RTT1, RTT2 and RTT3 states,
// and a step per new data segment.
// Results leave through a one-item holding register and an output register; a stall
// on the output holds the sequencer wherever it next wants to emit with the holding register full.
// Reset is synchronous; after it the block is idle and takes an item at once.
module window_sender_retx_rto #(
  parameter int WINDOW = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] ack_num,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] seq_num,
  output logic [31:0] byte_offset,
  output logic [15:0] seg_length,
  output logic        is_retransmit,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  wsr_pkg::cmd_t cmd;
  wsr_pkg::sts_t sts;
  logic          busy;

  assign in_stall  = busy;
  assign cfg_ready = 1'b1;

  wsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  wsr_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .ack_num       (ack_num),
    .now_ms        (now_ms),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .seq_num       (seq_num),
    .byte_offset   (byte_offset),
    .seg_length    (seg_length),
    .is_retransmit (is_retransmit),
    .last          (last)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after taking an item");

  // Nothing is left held back once the block is idle again.
  a_no_pending_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !sts.pend_valid)
    else $error("result left pending while idle");

  // Fill, first FIN, scan and flush operations only run when there is room to move the held result on.
  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == wsr_pkg::OP_FILL || cmd.op == wsr_pkg::OP_FIN_FIRST ||
     cmd.op == wsr_pkg::OP_SCAN_EV || cmd.op == wsr_pkg::OP_FLUSH) |-> sts.emit_ok)
    else $error("result produced without room");
`endif

endmodule
